// ----- sv/ascs_pkg.sv -----
package ascs_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_SCAN_PERIOD = 2'd0;
    localparam logic [1:0] REG_VOLT_CHAN   = 2'd1;
    localparam logic [1:0] REG_IBATT_CHAN  = 2'd2;
    localparam logic [1:0] REG_IBUS_CHAN   = 2'd3;

    localparam logic [15:0] RST_SCAN_PERIOD = 16'd100;
    localparam logic [5:0]  RST_VOLT_CHAN   = 6'd3;
    localparam logic [5:0]  RST_IBATT_CHAN  = 6'd4;
    localparam logic [5:0]  RST_IBUS_CHAN   = 6'd5;

    // Function codes of an input item
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_DONE  = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    // floor(v * 8.54) as (v * VIN_MUL) >> VIN_SHIFT, exact for 12-bit v
    localparam logic [23:0] VIN_MUL   = 24'd8954840;
    localparam int          VIN_SHIFT = 20;
    // floor(v / 15) as (v * IDIV_MUL) >> IDIV_SHIFT, exact for 12-bit v
    localparam logic [12:0] IDIV_MUL   = 13'd4370;
    localparam int          IDIV_SHIFT = 16;

    typedef struct packed {
        logic [15:0] scan_period_ms;
        logic [5:0]  batt_voltage_channel;
        logic [5:0]  batt_current_channel;
        logic [5:0]  bus_current_channel;
    } t_cfg;

    typedef struct packed {
        logic        start_conv;
        logic [5:0]  conv_channel;
        logic        start_accepted;
        logic [15:0] vin_mv;
        logic [8:0]  ibatt_ma;
        logic [8:0]  ibus_ma;
        logic        busy_res;
        logic        fault;
    } t_result;

endpackage

// ----- sv/adc_three_channel_scan_sequencer.sv -----
// Three-channel ADC scan sequencer: battery voltage, battery current, bus current.
// Input channel (i_in_valid / o_in_stall): one item per tick, conversion
// completion or software start request (i_func, i_adc_value, i_adc_channel).
// Output channel (o_out_valid / i_out_stall): exactly one result per item,
// giving the conversion to start next, whether a scan began, the scaled
// readings, busy and fault status.
// Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12
// (scan period, voltage channel, battery current channel, bus current channel).
// Timing: an accepted item waits in the input register; the combinational
// sequencer step then loads its result into the output register, and this
// transfer waits while the receiver stalls. Throughput is one item per cycle
// while the receiver does not stall, set by the input register feeding a
// combinational sequencer step into the result register.
// When the receiver stalls, the result holds and the input register keeps one
// more item; o_in_stall rises only when both are full.
// Synchronous active-low reset clears the sequencer to idle with zero readings,
// restores the register defaults (100, 3, 4, 5) and empties both stages.
// A fault persists until reset.
module adc_three_channel_scan_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_func,
    input  logic [11:0]                       i_adc_value,
    input  logic [5:0]                        i_adc_channel,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_start_conv,
    output logic [5:0]                        o_conv_channel,
    output logic                              o_start_accepted,
    output logic [15:0]                       o_vin_mv,
    output logic [8:0]                        o_ibatt_ma,
    output logic [8:0]                        o_ibus_ma,
    output logic                              o_busy_res,
    output logic                              o_fault,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ascs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [ascs_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [ascs_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import ascs_pkg::*;

    t_cfg        cfg;
    t_result     res;
    logic        r_in_valid;
    logic [1:0]  r_func;
    logic [11:0] r_adc_value;
    logic [5:0]  r_adc_channel;
    logic        r_out_valid;
    logic        advance;
    logic        fire;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (i_in_valid && !o_in_stall) begin
            r_func        <= i_func;
            r_adc_value   <= i_adc_value;
            r_adc_channel <= i_adc_channel;
        end
    end

    ascs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ascs_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_cfg         (cfg),
        .i_func        (r_func),
        .i_adc_value   (r_adc_value),
        .i_adc_channel (r_adc_channel),
        .o_res         (res)
    );

    assign o_out_valid      = r_out_valid;
    assign o_start_conv     = res.start_conv;
    assign o_conv_channel   = res.conv_channel;
    assign o_start_accepted = res.start_accepted;
    assign o_vin_mv         = res.vin_mv;
    assign o_ibatt_ma       = res.ibatt_ma;
    assign o_ibus_ma        = res.ibus_ma;
    assign o_busy_res       = res.busy_res;
    assign o_fault          = res.fault;

endmodule

// ----- sv/ascs_regs.sv -----
module ascs_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ascs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [ascs_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [ascs_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output ascs_pkg::t_cfg                    o_cfg
);
    import ascs_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_period_ms       <= RST_SCAN_PERIOD;
            r_cfg.batt_voltage_channel <= RST_VOLT_CHAN;
            r_cfg.batt_current_channel <= RST_IBATT_CHAN;
            r_cfg.bus_current_channel  <= RST_IBUS_CHAN;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SCAN_PERIOD: r_cfg.scan_period_ms       <= pwdata[15:0];
                REG_VOLT_CHAN:   r_cfg.batt_voltage_channel <= pwdata[5:0];
                REG_IBATT_CHAN:  r_cfg.batt_current_channel <= pwdata[5:0];
                REG_IBUS_CHAN:   r_cfg.bus_current_channel  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_SCAN_PERIOD: prdata[15:0] = r_cfg.scan_period_ms;
            REG_VOLT_CHAN:   prdata[5:0]  = r_cfg.batt_voltage_channel;
            REG_IBATT_CHAN:  prdata[5:0]  = r_cfg.batt_current_channel;
            REG_IBUS_CHAN:   prdata[5:0]  = r_cfg.bus_current_channel;
            default:         prdata       = '0;
        endcase
    end

endmodule

// ----- sv/ascs_scale.sv -----
module ascs_scale (
    input  logic [11:0] i_raw_volt,
    input  logic [11:0] i_raw_ibatt,
    input  logic [11:0] i_raw_ibus,
    output logic [15:0] o_vin_mv,
    output logic [8:0]  o_ibatt_ma,
    output logic [8:0]  o_ibus_ma
);
    import ascs_pkg::*;

    logic [35:0] vin_prod;
    logic [24:0] ibatt_prod;
    logic [24:0] ibus_prod;

    // Reciprocal multiplies; the rounding error stays below one LSB gap
    assign vin_prod   = {24'd0, i_raw_volt} * {12'd0, VIN_MUL};
    assign ibatt_prod = {13'd0, i_raw_ibatt} * {12'd0, IDIV_MUL};
    assign ibus_prod  = {13'd0, i_raw_ibus} * {12'd0, IDIV_MUL};

    assign o_vin_mv   = vin_prod[VIN_SHIFT +: 16];
    assign o_ibatt_ma = ibatt_prod[IDIV_SHIFT +: 9];
    assign o_ibus_ma  = ibus_prod[IDIV_SHIFT +: 9];

endmodule

// ----- sv/ascs_seq.sv -----
module ascs_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  ascs_pkg::t_cfg     i_cfg,
    input  logic [1:0]         i_func,
    input  logic [11:0]        i_adc_value,
    input  logic [5:0]         i_adc_channel,
    output ascs_pkg::t_result  o_res
);
    import ascs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_VOLT,
        PH_IBATT,
        PH_IBUS,
        PH_FAULT
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_elapsed, n_elapsed;
    logic [11:0] r_raw_volt, n_raw_volt;
    logic [11:0] r_raw_ibatt, n_raw_ibatt;
    logic [11:0] r_raw_ibus, n_raw_ibus;
    t_result     r_res, n_res;

    logic        start_conv;
    logic [5:0]  conv_channel;
    logic        accepted;
    logic [15:0] vin_mv;
    logic [8:0]  ibatt_ma;
    logic [8:0]  ibus_ma;

    always_comb begin
        n_phase      = r_phase;
        n_elapsed    = r_elapsed;
        n_raw_volt   = r_raw_volt;
        n_raw_ibatt  = r_raw_ibatt;
        n_raw_ibus   = r_raw_ibus;
        start_conv   = 1'b0;
        conv_channel = '0;
        accepted     = 1'b0;
        if (r_phase != PH_FAULT) begin
            case (i_func)
                FUNC_TICK: begin
                    if (r_elapsed != 16'hFFFF) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                    // counter restarts even if the scan start is refused
                    if (n_elapsed > i_cfg.scan_period_ms) begin
                        n_elapsed = '0;
                        if (r_phase == PH_IDLE) begin
                            n_phase      = PH_VOLT;
                            start_conv   = 1'b1;
                            conv_channel = i_cfg.batt_voltage_channel;
                            accepted     = 1'b1;
                        end
                    end
                end
                FUNC_DONE: begin
                    if (r_phase == PH_VOLT
                            && i_adc_channel == i_cfg.batt_voltage_channel) begin
                        n_raw_volt   = i_adc_value;
                        n_phase      = PH_IBATT;
                        start_conv   = 1'b1;
                        conv_channel = i_cfg.batt_current_channel;
                    end else if (r_phase == PH_IBATT
                            && i_adc_channel == i_cfg.batt_current_channel) begin
                        n_raw_ibatt  = i_adc_value;
                        n_phase      = PH_IBUS;
                        start_conv   = 1'b1;
                        conv_channel = i_cfg.bus_current_channel;
                    end else if (r_phase == PH_IBUS
                            && i_adc_channel == i_cfg.bus_current_channel) begin
                        n_raw_ibus = i_adc_value;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_phase = PH_FAULT;
                    end
                end
                FUNC_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_phase      = PH_VOLT;
                        start_conv   = 1'b1;
                        conv_channel = i_cfg.batt_voltage_channel;
                        accepted     = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    ascs_scale u_scale (
        .i_raw_volt  (n_raw_volt),
        .i_raw_ibatt (n_raw_ibatt),
        .i_raw_ibus  (n_raw_ibus),
        .o_vin_mv    (vin_mv),
        .o_ibatt_ma  (ibatt_ma),
        .o_ibus_ma   (ibus_ma)
    );

    always_comb begin
        n_res.start_conv     = start_conv;
        n_res.conv_channel   = conv_channel;
        n_res.start_accepted = accepted;
        n_res.vin_mv         = vin_mv;
        n_res.ibatt_ma       = ibatt_ma;
        n_res.ibus_ma        = ibus_ma;
        n_res.busy_res       = (n_phase == PH_VOLT) || (n_phase == PH_IBATT)
                               || (n_phase == PH_IBUS);
        n_res.fault          = (n_phase == PH_FAULT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_elapsed   <= '0;
            r_raw_volt  <= '0;
            r_raw_ibatt <= '0;
            r_raw_ibus  <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_raw_volt  <= n_raw_volt;
            r_raw_ibatt <= n_raw_ibatt;
            r_raw_ibus  <= n_raw_ibus;
        end
        if (i_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FAULT |=> r_phase == PH_FAULT)
        else $error("fault state left without reset");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && accepted |=> r_res.start_conv && r_res.busy_res && !r_res.fault
                               && r_phase == PH_VOLT)
        else $error("accepted scan start did not begin voltage conversion");

    a_fault_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && n_phase == PH_FAULT |=> !r_res.busy_res && !r_res.start_conv
                                          && !r_res.start_accepted)
        else $error("faulted result requests a conversion");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import ascs_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_VOLT,
        SEQ_IBATT,
        SEQ_IBUS,
        SEQ_FAULT
    } t_seq_phase;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] value;
        logic [5:0]  chan;
        logic        typed;
        t_result     want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_func = FUNC_TICK;
    logic [11:0]           i_adc_value = '0;
    logic [5:0]            i_adc_channel = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_start_conv;
    logic [5:0]            o_conv_channel;
    logic                  o_start_accepted;
    logic [15:0]           o_vin_mv;
    logic [8:0]            o_ibatt_ma;
    logic [8:0]            o_ibus_ma;
    logic                  o_busy_res;
    logic                  o_fault;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // sequencer shadow state
    t_cfg        cfg_shadow = '{RST_SCAN_PERIOD, RST_VOLT_CHAN, RST_IBATT_CHAN,
                                RST_IBUS_CHAN};
    t_seq_phase  seq_phase = SEQ_IDLE;
    logic [15:0] ms_count = '0;
    logic [11:0] raw_volt = '0;
    logic [11:0] raw_ibatt = '0;
    logic [11:0] raw_ibus = '0;

    t_result expected_results[$];
    int      bad_results = 0;
    int      result_count = 0;
    bit      jitter_on = 1'b1;

    // reset config: period 100, channels 3/4/5
    t_stim_row directed_rows [21] = '{
        '{FUNC_START,  12'h000, 6'd0,  1'b1,
            '{1'b1, 6'd3, 1'b1, 16'd0, 9'd0, 9'd0, 1'b1, 1'b0}},
        '{FUNC_START,  12'hFFF, 6'd63, 1'b1,
            '{1'b0, 6'd0, 1'b0, 16'd0, 9'd0, 9'd0, 1'b1, 1'b0}},
        '{FUNC_DONE,   12'hFFF, 6'd3,  1'b1,
            '{1'b1, 6'd4, 1'b0, 16'd34971, 9'd0, 9'd0, 1'b1, 1'b0}},
        '{FUNC_UNUSED, 12'hFFF, 6'd63, 1'b1,
            '{1'b0, 6'd0, 1'b0, 16'd34971, 9'd0, 9'd0, 1'b1, 1'b0}},
        '{FUNC_TICK,   12'h000, 6'd0,  1'b1,
            '{1'b0, 6'd0, 1'b0, 16'd34971, 9'd0, 9'd0, 1'b1, 1'b0}},
        '{FUNC_DONE,   12'hFFF, 6'd4,  1'b1,
            '{1'b1, 6'd5, 1'b0, 16'd34971, 9'd273, 9'd0, 1'b1, 1'b0}},
        '{FUNC_START,  12'h000, 6'd0,  1'b1,
            '{1'b0, 6'd0, 1'b0, 16'd34971, 9'd273, 9'd0, 1'b1, 1'b0}},
        '{FUNC_DONE,   12'hFFF, 6'd5,  1'b1,
            '{1'b0, 6'd0, 1'b0, 16'd34971, 9'd273, 9'd273, 1'b0, 1'b0}},
        '{FUNC_TICK,   12'hABC, 6'd42, 1'b0, '0},
        '{FUNC_START,  12'h123, 6'd21, 1'b0, '0},
        '{FUNC_DONE,   12'h000, 6'd3,  1'b1,
            '{1'b1, 6'd4, 1'b0, 16'd0, 9'd273, 9'd273, 1'b1, 1'b0}},
        '{FUNC_DONE,   12'h000, 6'd4,  1'b1,
            '{1'b1, 6'd5, 1'b0, 16'd0, 9'd0, 9'd273, 1'b1, 1'b0}},
        '{FUNC_DONE,   12'h000, 6'd5,  1'b1,
            '{1'b0, 6'd0, 1'b0, 16'd0, 9'd0, 9'd0, 1'b0, 1'b0}},
        '{FUNC_START,  12'h555, 6'd7,  1'b0, '0},
        '{FUNC_DONE,   12'hAAA, 6'd3,  1'b0, '0},
        '{FUNC_DONE,   12'h555, 6'd4,  1'b0, '0},
        '{FUNC_DONE,   12'd14,  6'd5,  1'b0, '0},
        '{FUNC_START,  12'h000, 6'd0,  1'b0, '0},
        '{FUNC_DONE,   12'd1,   6'd3,  1'b0, '0},
        '{FUNC_DONE,   12'd15,  6'd4,  1'b0, '0},
        '{FUNC_DONE,   12'd16,  6'd5,  1'b0, '0}
    };

    adc_three_channel_scan_sequencer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_adc_value      (i_adc_value),
        .i_adc_channel    (i_adc_channel),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_start_conv     (o_start_conv),
        .o_conv_channel   (o_conv_channel),
        .o_start_accepted (o_start_accepted),
        .o_vin_mv         (o_vin_mv),
        .o_ibatt_ma       (o_ibatt_ma),
        .o_ibus_ma        (o_ibus_ma),
        .o_busy_res       (o_busy_res),
        .o_fault          (o_fault),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= jitter_on && ($urandom_range(99) < 28);
    end

    function automatic bit scan_running();
        return seq_phase == SEQ_VOLT || seq_phase == SEQ_IBATT || seq_phase == SEQ_IBUS;
    endfunction

    function automatic logic [5:0] awaited_channel();
        case (seq_phase)
            SEQ_VOLT:  return cfg_shadow.batt_voltage_channel;
            SEQ_IBATT: return cfg_shadow.batt_current_channel;
            SEQ_IBUS:  return cfg_shadow.bus_current_channel;
            default:   return 6'd0;
        endcase
    endfunction

    function automatic void open_scan(inout t_result r);
        if (seq_phase == SEQ_IDLE) begin
            seq_phase = SEQ_VOLT;
            r.start_conv = 1'b1;
            r.conv_channel = cfg_shadow.batt_voltage_channel;
            r.start_accepted = 1'b1;
        end
    endfunction

    // advances the shadow sequencer by one item and returns its result
    function automatic t_result scan_step(logic [1:0] fn, logic [11:0] v, logic [5:0] ch);
        t_result r;
        r = '0;
        if (seq_phase != SEQ_FAULT) begin
            case (fn)
                FUNC_TICK: begin
                    if (ms_count != 16'hFFFF)
                        ms_count = ms_count + 16'd1;
                    if (ms_count > cfg_shadow.scan_period_ms) begin
                        // counter restarts even if the start is refused
                        ms_count = '0;
                        open_scan(r);
                    end
                end
                FUNC_DONE: begin
                    if (scan_running() && ch == awaited_channel()) begin
                        case (seq_phase)
                            SEQ_VOLT: begin
                                raw_volt = v;
                                seq_phase = SEQ_IBATT;
                                r.start_conv = 1'b1;
                                r.conv_channel = cfg_shadow.batt_current_channel;
                            end
                            SEQ_IBATT: begin
                                raw_ibatt = v;
                                seq_phase = SEQ_IBUS;
                                r.start_conv = 1'b1;
                                r.conv_channel = cfg_shadow.bus_current_channel;
                            end
                            default: begin
                                raw_ibus = v;
                                seq_phase = SEQ_IDLE;
                            end
                        endcase
                    end else begin
                        seq_phase = SEQ_FAULT;
                    end
                end
                FUNC_START: open_scan(r);
                default: ;
            endcase
        end
        r.vin_mv = 16'((32'(raw_volt) * 32'd854) / 32'd100);
        r.ibatt_ma = 9'(raw_ibatt / 12'd15);
        r.ibus_ma = 9'(raw_ibus / 12'd15);
        r.busy_res = scan_running();
        r.fault = (seq_phase == SEQ_FAULT);
        return r;
    endfunction

    function automatic string diff_fields(t_result w, t_result g);
        string s;
        s = "";
        if (g.start_conv !== w.start_conv)         s = {s, " start_conv"};
        if (g.conv_channel !== w.conv_channel)     s = {s, " conv_channel"};
        if (g.start_accepted !== w.start_accepted) s = {s, " start_accepted"};
        if (g.vin_mv !== w.vin_mv)                 s = {s, " vin_mv"};
        if (g.ibatt_ma !== w.ibatt_ma)             s = {s, " ibatt_ma"};
        if (g.ibus_ma !== w.ibus_ma)               s = {s, " ibus_ma"};
        if (g.busy_res !== w.busy_res)             s = {s, " busy_res"};
        if (g.fault !== w.fault)                   s = {s, " fault"};
        return s;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        string   diff;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_start_conv, o_conv_channel, o_start_accepted, o_vin_mv,
                   o_ibatt_ma, o_ibus_ma, o_busy_res, o_fault};
            if (expected_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result at %0t: %h", $realtime, got);
            end else begin
                want = expected_results.pop_front();
                diff = diff_fields(want, got);
                if (diff != "") begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display({"result %0d wrong in%s: exp conv=%0d ch=%0d acc=%0d",
                                  " vin=%0d ibatt=%0d ibus=%0d busy=%0d fault=%0d"},
                                 result_count, diff,
                                 want.start_conv, want.conv_channel, want.start_accepted,
                                 want.vin_mv, want.ibatt_ma, want.ibus_ma,
                                 want.busy_res, want.fault);
                        $display({"    got conv=%0d ch=%0d acc=%0d",
                                  " vin=%0d ibatt=%0d ibus=%0d busy=%0d fault=%0d"},
                                 got.start_conv, got.conv_channel, got.start_accepted,
                                 got.vin_mv, got.ibatt_ma, got.ibus_ma,
                                 got.busy_res, got.fault);
                    end
                end
            end
            result_count++;
        end
    end

    // called right after a falling edge; returns right after a falling edge
    task automatic push_item(input logic [1:0] fn, input logic [11:0] v,
                             input logic [5:0] ch, input bit typed, input t_result want);
        t_result predicted;
        if (jitter_on && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_adc_value <= v;
        i_adc_channel <= ch;
        do @(posedge i_clk); while (o_in_stall);
        predicted = scan_step(fn, v, ch);
        expected_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        logic [31:0] mask;
        logic [31:0] junk;
        mask = (idx == REG_SCAN_PERIOD) ? 32'h0000_FFFF : 32'h0000_003F;
        junk = $urandom;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        // bits above the register width must be dropped
        pwdata <= (junk & ~mask) | (32'(val) & mask);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SCAN_PERIOD: cfg_shadow.scan_period_ms = val;
            REG_VOLT_CHAN:   cfg_shadow.batt_voltage_channel = val[5:0];
            REG_IBATT_CHAN:  cfg_shadow.batt_current_channel = val[5:0];
            default:         cfg_shadow.bus_current_channel = val[5:0];
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] period, input logic [5:0] v_ch,
                             input logic [5:0] ib_ch, input logic [5:0] bus_ch);
        cfg_write(REG_SCAN_PERIOD, period);
        cfg_write(REG_VOLT_CHAN, 16'(v_ch));
        cfg_write(REG_IBATT_CHAN, 16'(ib_ch));
        cfg_write(REG_IBUS_CHAN, 16'(bus_ch));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // mostly legal scan traffic; broken_pct gives the share of bad completions
    task automatic next_scan_item(output logic [1:0] fn, output logic [11:0] v,
                                  output logic [5:0] ch, input int broken_pct);
        int pick;
        v = 12'($urandom_range(4095));
        ch = 6'($urandom_range(63));
        pick = $urandom_range(99);
        if (seq_phase == SEQ_FAULT) begin
            fn = 2'($urandom_range(3));
        end else if (pick < broken_pct) begin
            fn = FUNC_DONE;
            if (scan_running())
                ch = awaited_channel() ^ 6'($urandom_range(63, 1));
        end else if (scan_running()) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                fn = FUNC_DONE;
                ch = awaited_channel();
            end else if (pick < 75) begin
                fn = FUNC_TICK;
            end else if (pick < 88) begin
                fn = FUNC_START;
            end else begin
                fn = FUNC_UNUSED;
            end
        end else begin
            pick = $urandom_range(99);
            if (pick < 60)
                fn = FUNC_TICK;
            else if (pick < 92)
                fn = FUNC_START;
            else
                fn = FUNC_UNUSED;
        end
    endtask

    initial begin
        #2000000;
        $display("adc_three_channel_scan_sequencer: mismatch");
        $finish;
    end

    initial begin
        logic [1:0]  fn;
        logic [11:0] v;
        logic [5:0]  ch;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k])
            push_item(directed_rows[k].func, directed_rows[k].value, directed_rows[k].chan,
                      directed_rows[k].typed, directed_rows[k].want);
        settle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: configure(16'd0, 6'd0, 6'd63, 6'd1);
                1: configure(16'hFFFF, 6'd63, 6'd0, 6'd62);
                2: configure(RST_SCAN_PERIOD, RST_VOLT_CHAN, RST_IBATT_CHAN, RST_IBUS_CHAN);
                default: configure(16'($urandom_range(7)), 6'($urandom_range(63)),
                                   6'($urandom_range(63)), 6'($urandom_range(63)));
            endcase
            // one phase runs at full rate on both sides
            jitter_on = (p != 3);
            repeat (170) begin
                next_scan_item(fn, v, ch, 0);
                push_item(fn, v, ch, 1'b0, '0);
            end
            settle();
        end
        jitter_on = 1'b1;

        // a fault stops the block for good, so broken traffic comes last
        configure(16'($urandom_range(7)), 6'($urandom_range(63)),
                  6'($urandom_range(63)), 6'($urandom_range(63)));
        for (int n = 0; n < 90; n++) begin
            next_scan_item(fn, v, ch, (n < 40) ? 6 : ((n == 40) ? 100 : 0));
            push_item(fn, v, ch, 1'b0, '0);
        end
        settle();

        if (bad_results == 0)
            $display("adc_three_channel_scan_sequencer: match");
        else
            $display("adc_three_channel_scan_sequencer: mismatch");
        $finish;
    end

endmodule
